[rtl/ajdc_pkg.sv]
// Shared types and constants for the joystick axis conditioner.
// Used by ajdc_div and axis_jitter_deadzone_calibrator; no dependencies.
package ajdc_pkg;

   localparam int AX_COUNT     = 4;
   localparam int DEF_NUM_AXES = 4;
   localparam int SAMPLE_W     = 16;
   localparam int CAL_W        = 64;
   localparam int FILT_W       = 25;
   localparam int CSR_ADDR_W   = 3;
   localparam int DIV_W        = 34;   // dividend / quotient width
   localparam int DEN_W        = 16;
   localparam int CNT_W        = $clog2(DIV_W + 1);
   localparam logic [SAMPLE_W-1:0] MID_OUT = 16'd1024;

   // register index space: calibration words first, then filter words
   localparam logic CSR_BANK_CAL  = 1'b0;
   localparam logic CSR_BANK_FILT = 1'b1;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_W-1:0]  quot;
   } div_rsp_type;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_FILT = 9'b000000010,
      ST_CAL  = 9'b000000100,
      ST_MUL  = 9'b000001000,
      ST_GO   = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_POST = 9'b001000000,
      ST_NEXT = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

endpackage

[rtl/axis_jitter_deadzone_calibrator.sv]
// Four-axis conditioner: per-axis anti-jitter hold, then null-zone calibration.
// Depends on ajdc_pkg and ajdc_div.
//
// One report beat carries four 16-bit samples; one result beat carries four
// conditioned axes. The axes are worked one after another through a single
// bit-serial divider, which sets the rate: a calibrated axis outside the null
// zone needs one division when no side scaling is needed and two when it is,
// and the result register is loaded once the last axis is done.
// A new report is taken once the
// previous result sits in the output register, even if it is not yet read.
module axis_jitter_deadzone_calibrator #(
   parameter int NUM_AXES = ajdc_pkg::DEF_NUM_AXES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,  // axis0_raw..axis3_raw
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,  // axis0_out..axis3_out
   input  logic                              csr_we,
   input  logic [ajdc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ajdc_pkg::CAL_W-1:0]        csr_wdata
);

   localparam int AX = ajdc_pkg::AX_COUNT;
   localparam int SW = ajdc_pkg::SAMPLE_W;

   ajdc_pkg::state_type state_ff, state_in;

   logic [SW-1:0]                 raw_ff [AX];
   logic [SW-1:0]                 raw_in [AX];
   logic [SW-1:0]                 res_ff [AX];
   logic [SW-1:0]                 res_in [AX];
   logic [ajdc_pkg::CAL_W-1:0]    cal_ff [AX];
   logic [ajdc_pkg::FILT_W-1:0]   filt_ff [AX];
   logic [SW-1:0]                 held_ff [AX];
   logic [SW-1:0]                 held_in [AX];
   logic [7:0]                    rcnt_ff [AX];
   logic [7:0]                    rcnt_in [AX];
   logic [63:0]                   out_ff, out_in;
   logic                          ovld_ff, ovld_in;
   logic [1:0]                    idx_ff, idx_in;
   logic                          phase_ff, phase_in;
   logic [SW-1:0]                 s_ff, s_in;
   logic signed [19:0]            e_ff, e_in;
   logic signed [19:0]            d_ff, d_in;
   logic [SW-1:0]                 mulw_ff, mulw_in;
   logic [SW-1:0]                 den_ff, den_in;
   logic [SW-1:0]                 nar_ff, nar_in;
   logic                          left_ff, left_in;
   logic                          neg_ff, neg_in;
   logic [ajdc_pkg::DIV_W-1:0]    prod_ff, prod_in;

   ajdc_pkg::div_req_type dreq;
   ajdc_pkg::div_rsp_type drsp;

   // per-axis views
   logic                  active;
   logic [ajdc_pkg::FILT_W-1:0] fw;
   logic [ajdc_pkg::CAL_W-1:0]  cw;
   logic signed [17:0]    sx, heldx, marg, lo_j, hi_j;
   logic                  outside;
   logic signed [17:0]    nul, lft, cen, rgt, lo, hi, sv, scx, sc;
   logic [SW-1:0]         wl, wr, nar;
   logic signed [19:0]    e;
   logic signed [36:0]    p;
   logic [36:0]           pmag;
   logic signed [19:0]    x;
   logic [19:0]           xmag;
   logic [SW-1:0]         q16;

   ajdc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   assign req_tready = state_ff == ajdc_pkg::ST_IDLE;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = out_ff;

   assign dreq.start = state_ff == ajdc_pkg::ST_GO;
   assign dreq.num   = prod_ff;
   assign dreq.den   = den_ff;

   always_comb begin
      active  = {1'b0, idx_ff} < 3'(NUM_AXES);
      fw      = filt_ff[idx_ff];
      cw      = cal_ff[idx_ff];
      sx      = 18'(raw_ff[idx_ff]);
      heldx   = 18'(held_ff[idx_ff]);
      marg    = 18'(fw[23:8]);
      lo_j    = heldx - marg;
      hi_j    = heldx + marg;
      outside = (sx < lo_j) || (sx > hi_j);
      nul     = 18'(cw[15:1]);
      lft     = 18'(cw[31:16]);
      cen     = 18'(cw[47:32]);
      rgt     = 18'(cw[63:48]);
      lo      = cen - nul;
      hi      = cen + nul;
      wl      = SW'(lo - lft);
      wr      = SW'(rgt - hi);
      nar     = (wl < wr) ? wl : wr;
      // signed copy of the filtered sample: lo can go below zero
      sv      = 18'(s_ff);
      scx     = (sv < lft) ? lft : sv;
      sc      = (scx > rgt) ? rgt : scx;
      e       = (sc < cen) ? 20'(lo - sc) : 20'(sc - hi);
      p       = 37'(e_ff) * 37'(signed'({1'b0, mulw_ff}));
      pmag    = p[36] ? 37'(-p) : 37'(p);
      x       = d_ff + 20'(signed'({1'b0, nar_ff}));
      xmag    = x[19] ? 20'(-x) : 20'(x);
      q16     = neg_ff ? SW'(-drsp.quot[SW-1:0]) : drsp.quot[SW-1:0];

      state_in = state_ff;
      raw_in   = raw_ff;
      res_in   = res_ff;
      held_in  = held_ff;
      rcnt_in  = rcnt_ff;
      out_in   = out_ff;
      ovld_in  = ovld_ff && !rsp_tready;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      d_in     = d_ff;
      mulw_in  = mulw_ff;
      den_in   = den_ff;
      nar_in   = nar_ff;
      left_in  = left_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;

      unique case (state_ff)
         ajdc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < AX; i++) raw_in[i] = req_tdata[i*SW +: SW];
               idx_in   = '0;
               state_in = ajdc_pkg::ST_FILT;
            end
         end
         ajdc_pkg::ST_FILT: begin
            s_in = raw_ff[idx_ff];
            if (!active) begin
               res_in[idx_ff] = raw_ff[idx_ff];
               state_in       = ajdc_pkg::ST_NEXT;
            end else begin
               if (fw[24]) begin
                  if (outside || rcnt_ff[idx_ff] >= fw[7:0]) begin
                     rcnt_in[idx_ff] = '0;
                     held_in[idx_ff] = raw_ff[idx_ff];
                  end else begin
                     rcnt_in[idx_ff] = rcnt_ff[idx_ff] + 1'b1;
                     s_in            = held_ff[idx_ff];
                  end
               end
               state_in = ajdc_pkg::ST_CAL;
            end
         end
         ajdc_pkg::ST_CAL: begin
            nar_in  = nar;
            left_in = sc < cen;
            e_in    = e;
            if (!cw[0]) begin
               res_in[idx_ff] = s_ff;
               state_in       = ajdc_pkg::ST_NEXT;
            end else if (sv >= lo && sv <= hi) begin
               res_in[idx_ff] = ajdc_pkg::MID_OUT;
               state_in       = ajdc_pkg::ST_NEXT;
            end else if (nar == '0) begin
               res_in[idx_ff] = ajdc_pkg::MID_OUT;
               state_in       = ajdc_pkg::ST_NEXT;
            end else if ((sc < cen) ? (wl > wr) : (wr > wl)) begin
               // narrower side rescales the wider one: d * narrow / wide
               mulw_in  = (sc < cen) ? wr : wl;
               den_in   = (sc < cen) ? wl : wr;
               state_in = ajdc_pkg::ST_MUL;
            end else begin
               d_in     = (sc < cen) ? -e : e;
               state_in = ajdc_pkg::ST_POST;
            end
         end
         ajdc_pkg::ST_MUL: begin
            neg_in   = p[36] ^ left_ff;
            prod_in  = pmag[ajdc_pkg::DIV_W-1:0];
            phase_in = 1'b0;
            state_in = ajdc_pkg::ST_GO;
         end
         ajdc_pkg::ST_GO: begin
            state_in = ajdc_pkg::ST_DIV;
         end
         ajdc_pkg::ST_DIV: begin
            if (drsp.done) begin
               if (!phase_ff) begin
                  d_in     = neg_ff ? -20'(drsp.quot) : 20'(drsp.quot);
                  state_in = ajdc_pkg::ST_POST;
               end else begin
                  res_in[idx_ff] = q16;
                  state_in       = ajdc_pkg::ST_NEXT;
               end
            end
         end
         ajdc_pkg::ST_POST: begin
            // (d + nar) * 1024 / nar, truncated toward zero
            neg_in   = x[19];
            prod_in  = ajdc_pkg::DIV_W'({xmag, 10'b0});
            den_in   = nar_ff;
            phase_in = 1'b1;
            state_in = ajdc_pkg::ST_GO;
         end
         ajdc_pkg::ST_NEXT: begin
            if (idx_ff == 2'(AX - 1)) begin
               state_in = ajdc_pkg::ST_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ajdc_pkg::ST_FILT;
            end
         end
         ajdc_pkg::ST_OUT: begin
            if (!ovld_ff || rsp_tready) begin
               for (int i = 0; i < AX; i++) out_in[i*SW +: SW] = res_ff[i];
               ovld_in  = 1'b1;
               state_in = ajdc_pkg::ST_IDLE;
            end
         end
         default: state_in = ajdc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      d_ff    <= d_in;
      mulw_ff <= mulw_in;
      den_ff  <= den_in;
      nar_ff  <= nar_in;
      left_ff <= left_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= ajdc_pkg::ST_IDLE;
         ovld_ff  <= 1'b0;
         idx_ff   <= '0;
         phase_ff <= 1'b0;
         for (int i = 0; i < AX; i++) begin
            held_ff[i] <= '0;
            rcnt_ff[i] <= '0;
            cal_ff[i]  <= '0;
            filt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ovld_ff  <= ovld_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         rcnt_ff  <= rcnt_in;
         if (csr_we) begin
            if (csr_addr[2] == ajdc_pkg::CSR_BANK_CAL) begin
               cal_ff[csr_addr[1:0]] <= csr_wdata;
            end else begin
               filt_ff[csr_addr[1:0]] <= csr_wdata[ajdc_pkg::FILT_W-1:0];
            end
         end
      end
   end

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> state_ff == ajdc_pkg::ST_DIV)
      else $error("divider finished outside the divide wait");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ajdc_pkg::ST_FILT && idx_ff == '0)
      else $error("accepted report did not start at axis 0");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ajdc_pkg::ST_OUT)
      else $error("result beat raised outside the output step");

   a_div_idle_on_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ajdc_pkg::ST_OUT |-> !drsp.busy)
      else $error("divider still busy when the result is loaded");

endmodule

[rtl/ajdc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ajdc_pkg for widths and the request/response structs.
module ajdc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ajdc_pkg::div_req_type req,
   output ajdc_pkg::div_rsp_type rsp
);

   logic [ajdc_pkg::DIV_W-1:0] num_ff, num_in;
   logic [ajdc_pkg::DEN_W:0]   rem_ff, rem_in;
   logic [ajdc_pkg::DEN_W-1:0] den_ff, den_in;
   logic [ajdc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ajdc_pkg::DEN_W:0]   rem_sh;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff[ajdc_pkg::DEN_W-1:0], num_ff[ajdc_pkg::DIV_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = ajdc_pkg::CNT_W'(ajdc_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         num_in = {num_ff[ajdc_pkg::DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ajdc_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = num_ff;

endmodule

[verif/tb_axis_jitter_deadzone_calibrator.sv]
// Testbench for axis_jitter_deadzone_calibrator: directed and random reports,
// per-axis settings changed between phases, results checked against a predictor.
// Depends on ajdc_pkg and the block RTL.
class axis_scoreboard;
   logic [63:0] cal_word [4];
   logic [24:0] filt_word [4];
   logic [15:0] held_pos [4];
   logic [7:0]  rep_cnt [4];
   logic [63:0] pending_reports [$];
   int          mismatches;

   function void clear();
      for (int a = 0; a < 4; a++) begin
         cal_word[a] = '0;
         filt_word[a] = '0;
         held_pos[a] = '0;
         rep_cnt[a] = '0;
      end
      mismatches = 0;
   endfunction

   function void set_reg(int idx, logic [63:0] v);
      if (idx < 4) cal_word[idx] = v;
      else if (idx < 8) filt_word[idx-4] = v[24:0];
   endfunction

   function longint antijitter(int a, longint s);
      longint margin, held;
      margin = filt_word[a][23:8];
      held = held_pos[a];
      if (!filt_word[a][24]) return s;
      if (s < held - margin || s > held + margin) begin
         rep_cnt[a] = 0;
         held_pos[a] = s[15:0];
         return s;
      end
      if (rep_cnt[a] < filt_word[a][7:0]) begin
         rep_cnt[a] = rep_cnt[a] + 8'd1;
         return held;
      end
      rep_cnt[a] = 0;
      held_pos[a] = s[15:0];
      return s;
   endfunction

   function longint deadzone_map(int a, longint s);
      longint nul, lft, cen, rgt, lo, hi, wl, wr, nar, d, t;
      logic [63:0] w;
      w = cal_word[a];
      nul = w[15:1];
      lft = w[31:16];
      cen = w[47:32];
      rgt = w[63:48];
      lo = cen - nul;
      hi = cen + nul;
      t = lo - lft; wl = t & 64'hFFFF;
      t = rgt - hi; wr = t & 64'hFFFF;
      nar = (wl < wr) ? wl : wr;
      if (!w[0]) return s;
      if (s >= lo && s <= hi) return 1024;
      if (s < lft) s = lft;
      if (s > rgt) s = rgt;
      if (nar == 0) return 1024;
      if (s < cen) begin
         d = lo - s;
         if (wl > wr) d = (d * wr) / wl;
         d = -d;
      end else begin
         d = s - hi;
         if (wr > wl) d = (d * wl) / wr;
      end
      return ((d + nar) * 2048) / (2 * nar);
   endfunction

   function void note_report(logic [63:0] raw);
      logic [63:0] res;
      longint s;
      for (int a = 0; a < 4; a++) begin
         s = raw[a*16 +: 16];
         s = antijitter(a, s);
         s = deadzone_map(a, s);
         res[a*16 +: 16] = s[15:0];
      end
      pending_reports.push_back(res);
   endfunction

   function void check_result(logic [63:0] got);
      logic [63:0] exp_res;
      if (pending_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat %h", got);
         return;
      end
      exp_res = pending_reports.pop_front();
      for (int a = 0; a < 4; a++)
         if (exp_res[a*16 +: 16] !== got[a*16 +: 16]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("axis%0d out: expected %0d got %0d", a,
                        exp_res[a*16 +: 16], got[a*16 +: 16]);
         end
   endfunction
endclass

module tb_axis_jitter_deadzone_calibrator;

   localparam int REG_CAL0  = 0;
   localparam int REG_FILT0 = 4;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic csr_we = 0;
   logic [ajdc_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ajdc_pkg::CAL_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycles = 0;
   axis_scoreboard axes_sb;

   axis_jitter_deadzone_calibrator DUT (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random stalls, check on each accepted beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) axes_sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one write beat, then the enable goes low before the task returns
   task automatic write_reg(int idx, logic [63:0] v);
      csr_we <= 1;
      csr_addr <= idx[ajdc_pkg::CSR_ADDR_W-1:0];
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      axes_sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // valid stays up after the beat so a following report can reuse it
   task automatic send_report(logic [63:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      axes_sb.note_report(raw);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (axes_sb.pending_reports.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [63:0] make_cal(bit en, logic [14:0] nul,
                                            logic [15:0] l, logic [15:0] c,
                                            logic [15:0] r);
      return {r, c, l, nul, en};
   endfunction

   // mostly sane settings, sometimes raw extremes or misconfigured
   function automatic logic [63:0] rand_cal();
      logic [15:0] c, l, r;
      logic [14:0] n;
      if ($urandom_range(9) == 0) return {$urandom, $urandom};
      c = 16'($urandom_range(20000, 45000));
      n = 15'($urandom_range(0, 3000));
      l = c - 16'(n) - 16'($urandom_range(0, 20000));
      r = c + 16'(n) + 16'($urandom_range(0, 20000));
      return make_cal($urandom_range(3) != 0, n, l, c, r);
   endfunction

   function automatic logic [24:0] rand_filt();
      return {1'($urandom_range(3) != 0), 16'($urandom_range(0, 2000)),
              8'($urandom_range(0, 6))};
   endfunction

   function automatic logic [63:0] rand_report(logic [63:0] prev);
      logic [63:0] r;
      for (int a = 0; a < 4; a++)
         case ($urandom_range(3))
            0: r[a*16 +: 16] = 16'($urandom);
            1: r[a*16 +: 16] = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
            default: r[a*16 +: 16] = prev[a*16 +: 16] + 16'($urandom_range(0, 600))
                                     - 16'd300;
         endcase
      return r;
   endfunction

   initial begin
      logic [63:0] last_raw;
      axes_sb = new();
      axes_sb.clear();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: bypass, then extreme settings
      send_report(64'h0000_FFFF_8000_0001);
      send_report(64'hFFFF_0000_7FFF_FFFE);
      drain();
      write_reg(REG_CAL0,     make_cal(1, 15'd100, 16'd1000, 16'd30000, 16'd60000));
      write_reg(REG_CAL0 + 1, make_cal(1, 15'd0, 16'd0, 16'd32768, 16'hFFFF));
      write_reg(REG_CAL0 + 2, make_cal(1, 15'd50, 16'd30000, 16'd30000, 16'd100));
      write_reg(REG_CAL0 + 3, make_cal(1, 15'h7FFF, 16'hFFFF, 16'd0, 16'd0));
      write_reg(REG_FILT0,     64'({1'b1, 16'd200, 8'd3}));
      write_reg(REG_FILT0 + 1, 64'({1'b1, 16'hFFFF, 8'hFF}));
      write_reg(REG_FILT0 + 2, 64'({1'b1, 16'd0, 8'd0}));
      write_reg(REG_FILT0 + 3, 64'd0);
      send_report(64'h0000_0000_0000_0000);
      send_report(64'hFFFF_FFFF_FFFF_FFFF);
      send_report(64'h7530_7530_7530_7530);
      send_report(64'h7540_7550_7540_7560);
      send_report(64'h7550_0001_7550_7550);
      send_report(64'h7550_FFFE_7550_7550);
      send_report(64'h7550_1234_7550_0400);
      send_report(64'hEA60_8000_0064_EA61);
      send_report(64'h03E8_8000_03E7_0000);
      drain();

      last_raw = '0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         for (int i = 0; i < 4; i++) write_reg(REG_CAL0 + i, rand_cal());
         for (int i = 0; i < 4; i++) write_reg(REG_FILT0 + i, 64'(rand_filt()));
         for (int n = 0; n < 300; n++) begin
            last_raw = rand_report(last_raw);
            send_report(last_raw);
         end
         drain();
      end

      if (axes_sb.mismatches == 0 && axes_sb.pending_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
